### sv/bglc_pkg.sv
`timescale 1ns / 1ps

package bglc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W = 16;
    localparam int AVG_W = 12;
    localparam int PCT_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESHOLD = 2'd0,
        CFG_CUTOFF_EN     = 2'd1
    } cfg_idx_t;

    localparam int GAUGE_POINTS = 6;
    localparam int GAUGE_SEGS = GAUGE_POINTS - 1;
    localparam int SEG_W = 3;
    localparam int OFS_W = 7;
    localparam int SCALED_W = 12;
    localparam int GAUGE_SHIFT = 19;
    localparam int GAUGE_MUL_W = 15;
    localparam int GAUGE_PROD_W = SCALED_W + GAUGE_MUL_W;
    localparam int Q_W = 5;

    localparam logic [PCT_W-1:0] GAUGE_STEP = 7'd20;
    localparam logic [PCT_W-1:0] GAUGE_FULL = 7'd100;

    localparam int A0 = 2951;
    localparam int A1 = 3019;
    localparam int A2 = 3037;
    localparam int A3 = 3091;
    localparam int A4 = 3124;
    localparam int A5 = 3231;

    localparam logic [AVG_W-1:0] GAUGE_ADC [GAUGE_POINTS] = '{
        AVG_W'(A0), AVG_W'(A1), AVG_W'(A2), AVG_W'(A3), AVG_W'(A4), AVG_W'(A5)
    };

    // ceil(2^19 / span), exact floor division for products below 2^12
    localparam logic [GAUGE_MUL_W-1:0] GAUGE_MUL [GAUGE_SEGS] = '{
        GAUGE_MUL_W'((2**GAUGE_SHIFT + (A1 - A0) - 1) / (A1 - A0)),
        GAUGE_MUL_W'((2**GAUGE_SHIFT + (A2 - A1) - 1) / (A2 - A1)),
        GAUGE_MUL_W'((2**GAUGE_SHIFT + (A3 - A2) - 1) / (A3 - A2)),
        GAUGE_MUL_W'((2**GAUGE_SHIFT + (A4 - A3) - 1) / (A4 - A3)),
        GAUGE_MUL_W'((2**GAUGE_SHIFT + (A5 - A4) - 1) / (A5 - A4))
    };

endpackage

### sv/bglc_if.sv
`timescale 1ns / 1ps

interface bglc_in_if
    import bglc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                charging;

    modport source (output valid, output sample, output charging, input ready);
    modport sink (input valid, input sample, input charging, output ready);
endinterface

interface bglc_out_if
    import bglc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] average;
    logic [PCT_W-1:0] percent;
    logic             was_charging;
    logic             power_off;

    modport source (output valid, output average, output percent, output was_charging,
                    output power_off, input ready);
    modport sink (input valid, input average, input percent, input was_charging,
                  input power_off, output ready);
endinterface

interface bglc_cfg_if
    import bglc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/battery_gauge_with_low_cutoff.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                    Transaction
// samples   in   sample[11:0], charging                     valid & ready
// results   out  average[11:0], percent[6:0], was_charging, valid & ready
//                power_off
// cfg       in   index[1:0], data[11:0]                     valid & ready
//
// One sample per cycle while samples.ready is high; after the batch's last sample a result
// passes the batch register, divide-by-batch multiply and interpolation multiply in that order.
// rst_n clears the batch accumulator, pipeline valids and both registers.
// results.ready low stalls the pipeline; samples.ready drops only when all stages are full.
// cfg is always ready.

module battery_gauge_with_low_cutoff
    import bglc_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    bglc_in_if.sink      samples,
    bglc_out_if.source   results,
    bglc_cfg_if.sink     cfg
);

    localparam int CntW = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic [CntW-1:0] LastCnt = CntW'(SAMPLES_PER_READING - 1);
    localparam int DivShift = SUM_W + $clog2(SAMPLES_PER_READING);
    localparam int DivMulW = DivShift + 1;
    localparam int DivProdW = SUM_W + DivMulW;
    localparam logic [DivMulW-1:0] DivMul =
        DivMulW'((2**DivShift + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

    logic [AVG_W-1:0] threshold_reg;
    logic             cutoff_en_reg;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             latch_reg, latch_next;

    logic             s1_v_reg, s1_v_next;
    logic [SUM_W-1:0] s1_sum_reg;
    logic             s1_chg_reg;

    logic             s2_v_reg, s2_v_next;
    logic [AVG_W-1:0] s2_avg_reg;
    logic             s2_chg_reg;

    logic             out_v_reg, out_v_next;
    logic [AVG_W-1:0] out_avg_reg;
    logic [PCT_W-1:0] out_pct_reg;
    logic             out_chg_reg;
    logic             out_off_reg;

    logic out_free, s2_free, s1_free;
    logic in_acc, batch_done, cur_latch;

    logic [DivProdW-1:0] div_prod;

    logic [SEG_W-1:0]        seg;
    logic [OFS_W-1:0]        ofs;
    logic [SCALED_W-1:0]     scaled;
    logic [GAUGE_PROD_W-1:0] q_prod;
    logic [PCT_W-1:0]        pct;
    logic                    off;

    assign out_free = !out_v_reg || results.ready;
    assign s2_free  = !s2_v_reg || out_free;
    assign s1_free  = !s1_v_reg || s2_free;

    assign samples.ready = s1_free;
    assign cfg.ready     = 1'b1;

    assign in_acc     = samples.valid && samples.ready;
    assign batch_done = in_acc && (cnt_reg == LastCnt);
    assign cur_latch  = (cnt_reg == '0) ? samples.charging : latch_reg;

    always_comb
    begin
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        latch_next = latch_reg;
        if (in_acc)
        begin
            latch_next = cur_latch;
            if (batch_done)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_reg + SUM_W'(samples.sample);
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    assign s1_v_next  = batch_done || (s1_v_reg && !s2_free);
    assign s2_v_next  = (s1_v_reg && s2_free) || (s2_v_reg && !out_free);
    assign out_v_next = (s2_v_reg && out_free) || (out_v_reg && !results.ready);

    assign div_prod = DivProdW'(s1_sum_reg) * DivProdW'(DivMul);

    always_comb
    begin
        seg = '0;
        for (int i = 1; i < GAUGE_SEGS; i++)
        begin
            if (s2_avg_reg >= GAUGE_ADC[i])
            begin
                seg = SEG_W'(i);
            end
        end
    end

    assign ofs    = OFS_W'(s2_avg_reg - GAUGE_ADC[seg]);
    assign scaled = SCALED_W'(ofs) * SCALED_W'(GAUGE_STEP);
    assign q_prod = GAUGE_PROD_W'(scaled) * GAUGE_PROD_W'(GAUGE_MUL[seg]);

    always_comb
    begin
        if (s2_avg_reg < GAUGE_ADC[0])
        begin
            pct = '0;
        end
        else if (s2_avg_reg >= GAUGE_ADC[GAUGE_POINTS-1])
        begin
            pct = GAUGE_FULL;
        end
        else
        begin
            pct = PCT_W'(seg) * GAUGE_STEP + PCT_W'(q_prod[GAUGE_SHIFT +: Q_W]);
        end
    end

    assign off = !s2_chg_reg && cutoff_en_reg && (s2_avg_reg < threshold_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            cutoff_en_reg <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            latch_reg     <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_LOW_THRESHOLD: threshold_reg <= AVG_W'(cfg.data);
                    CFG_CUTOFF_EN:     cutoff_en_reg <= cfg.data[0];
                    default:           ;
                endcase
            end
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            latch_reg <= latch_next;
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (batch_done)
        begin
            s1_sum_reg <= sum_reg + SUM_W'(samples.sample);
            s1_chg_reg <= cur_latch;
        end
        if (s1_v_reg && s2_free)
        begin
            s2_avg_reg <= div_prod[DivShift +: AVG_W];
            s2_chg_reg <= s1_chg_reg;
        end
        if (s2_v_reg && out_free)
        begin
            out_avg_reg <= s2_avg_reg;
            out_pct_reg <= pct;
            out_chg_reg <= s2_chg_reg;
            out_off_reg <= off;
        end
    end

    assign results.valid        = out_v_reg;
    assign results.average      = out_avg_reg;
    assign results.percent      = out_pct_reg;
    assign results.was_charging = out_chg_reg;
    assign results.power_off    = out_off_reg;

`ifndef ASSERT_OFF
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.percent <= GAUGE_FULL))
        else $error("percent above full scale");

    a_off_rule: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.power_off) |-> (!results.was_charging && cutoff_en_reg))
        else $error("power_off raised while charging or cutoff disabled");

    a_full_top: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.average >= GAUGE_ADC[GAUGE_POINTS-1]))
            |-> (results.percent == GAUGE_FULL))
        else $error("percent not full above last breakpoint");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LastCnt)
        else $error("sample count beyond batch size");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb
    import bglc_pkg::*;
();

    localparam int BATCH = 10;
    localparam int KNEE_COUNT = 6;
    localparam int KNEE_ADC [KNEE_COUNT] = '{2951, 3019, 3037, 3091, 3124, 3231};
    localparam int LEVEL_STEP = 20;
    localparam int LEVEL_FULL = 100;
    localparam int PIPE_SETTLE = 6;
    localparam int TAIL_CYCLES = 10;
    localparam int QUIET_LIMIT = 2000;
    localparam int IDLE_PCT = 15;
    localparam int RANDOM_PHASES = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

    typedef struct packed {
        logic [AVG_W-1:0] average;
        logic [PCT_W-1:0] percent;
        logic             was_charging;
        logic             power_off;
    } gauge_reading_t;

    logic clk = 1'b0;
    logic rst_n;

    bglc_in_if  samples();
    bglc_out_if results();
    bglc_cfg_if cfg();

    battery_gauge_with_low_cutoff #(
        .SAMPLES_PER_READING(BATCH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples),
        .results(results),
        .cfg(cfg)
    );

    always #1 clk = ~clk;

    gauge_reading_t  reading_q[$];
    logic [AVG_W-1:0] thresh_reg;
    logic            cutoff_reg;
    logic [SUM_W-1:0] acc_sum;
    int              acc_cnt;
    logic            acc_chg;
    bit              calm;
    int              mismatches = 0;
    int              quiet_cycles = 0;

    function automatic logic [PCT_W-1:0] level_of(input int x);
        int seg;
        if (x < KNEE_ADC[0])
            return '0;
        if (x >= KNEE_ADC[KNEE_COUNT-1])
            return PCT_W'(LEVEL_FULL);
        seg = 0;
        while (x >= KNEE_ADC[seg+1])
            seg++;
        return PCT_W'(LEVEL_STEP * seg + (x - KNEE_ADC[seg]) * LEVEL_STEP /
                      (KNEE_ADC[seg+1] - KNEE_ADC[seg]));
    endfunction

    function automatic void absorb_sample(input logic [SAMPLE_W-1:0] s, input logic c);
        gauge_reading_t r;
        if (acc_cnt == 0)
            acc_chg = c;
        acc_sum = acc_sum + SUM_W'(s);
        acc_cnt++;
        if (acc_cnt < BATCH)
            return;
        r.average = AVG_W'(int'(acc_sum) / BATCH);
        r.percent = level_of(int'(r.average));
        r.was_charging = acc_chg;
        r.power_off = !acc_chg && cutoff_reg && (r.average < thresh_reg);
        reading_q.push_back(r);
        acc_sum = '0;
        acc_cnt = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_LOW_THRESHOLD: thresh_reg = val;
            CFG_CUTOFF_EN:     cutoff_reg = val[0];
            default:           ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // called and returns at a falling edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic c);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid <= 1'b1;
        samples.sample <= s;
        samples.charging <= c;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        absorb_sample(s, c);
        @(negedge clk);
    endtask

    task automatic drain_results();
        samples.valid <= 1'b0;
        while (reading_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    // leaves cfg.valid high; caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic test_empty_cells();
        repeat (BATCH) send_sample('0, 1'b0);
    endtask

    task automatic test_cutoff_mid_batch();
        send_sample('1, 1'b0);
        repeat (BATCH / 2 - 1) send_sample('1, 1'b1);
        drain_results();
        write_reg(CFG_LOW_THRESHOLD, '1);
        write_reg(CFG_CUTOFF_EN, '1);
        write_reg(CFG_IDX_SPARE2, '0);
        write_reg(CFG_IDX_SPARE3, '0);
        cfg.valid <= 1'b0;
        repeat (BATCH - BATCH / 2) send_sample(12'd4094, 1'b1);
    endtask

    task automatic random_items(input int unsigned n_items);
        int unsigned k;
        int unsigned pick;
        int          target;
        bit          spread;
        logic [SAMPLE_W-1:0] s;
        target = 0;
        spread = 1'b1;
        for (k = 0; k < n_items; k++)
        begin
            if (acc_cnt == 0)
            begin
                pick = $urandom_range(99);
                spread = (pick >= 85);
                if (pick < 60)
                    target = KNEE_ADC[$urandom_range(KNEE_COUNT-1)] + int'($urandom_range(4)) - 2;
                else
                    target = int'($urandom_range(3300, 2900));
            end
            if (spread)
                s = SAMPLE_W'($urandom_range(4095));
            else
                s = SAMPLE_W'(target + int'($urandom_range(6)) - 3);
            send_sample(s, 1'($urandom_range(1)));
        end
    endtask

    task automatic test_random_soak();
        int ph;
        logic [CFG_DATA_W-1:0] thr;
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_results();
            case (ph % 4)
                0:       thr = CFG_DATA_W'($urandom);
                1:       thr = '1;
                2:       thr = '0;
                default: thr = CFG_DATA_W'($urandom_range(3300, 2900));
            endcase
            write_reg(CFG_LOW_THRESHOLD, thr);
            write_reg(CFG_CUTOFF_EN, {11'($urandom), 1'(ph % 3 != 2)});
            if (ph == 7)
                write_reg(CFG_IDX_SPARE3, CFG_DATA_W'($urandom));
            cfg.valid <= 1'b0;
            calm = (ph == 5);
            random_items($urandom_range(140, 60));
        end
        calm = 1'b0;
    endtask

    always @(negedge clk)
        results.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin : check_results
        gauge_reading_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (reading_q.size() == 0)
                report_mismatch("result with no reading expected");
            else
            begin
                want = reading_q.pop_front();
                if (results.average !== want.average)
                    report_mismatch($sformatf("average %0d, want %0d",
                                              results.average, want.average));
                if (results.percent !== want.percent)
                    report_mismatch($sformatf("percent %0d, want %0d",
                                              results.percent, want.percent));
                if (results.was_charging !== want.was_charging)
                    report_mismatch($sformatf("was_charging %0b, want %0b",
                                              results.was_charging, want.was_charging));
                if (results.power_off !== want.power_off)
                    report_mismatch($sformatf("power_off %0b, want %0b",
                                              results.power_off, want.power_off));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        calm = 1'b0;
        samples.valid = 1'b0;
        samples.sample = '0;
        samples.charging = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_LOW_THRESHOLD;
        cfg.data = '0;
        thresh_reg = '0;
        cutoff_reg = 1'b0;
        acc_sum = '0;
        acc_cnt = 0;
        acc_chg = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_cells();
        test_cutoff_mid_batch();
        test_random_soak();

        samples.valid <= 1'b0;
        while (reading_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
sv/bglc_pkg.sv
sv/bglc_if.sv
sv/battery_gauge_with_low_cutoff.sv
tb/tb.sv
